### rtl/rtnp_pkg.sv
// package for the ring-tone text note parser
// types, character codes, parse phases and the controller/datapath interface
// no dependencies
`default_nettype none

package rtnp_pkg;

    // fixed field widths
    localparam int CHAR_W      = 8;
    localparam int OCT_W       = 4;
    localparam int SEMI_W      = 4;
    localparam int DUR_W       = 19;
    localparam int SHIFT_W     = 2;
    localparam int VAL_W       = 10;
    localparam int DIVIDEND_W  = 18;
    localparam int DIVISOR_W   = 10;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    // tempo and song defaults
    localparam logic [DIVIDEND_W-1:0] TEMPO_NUM   = 18'd60000;
    localparam logic [VAL_W-1:0]      BPM_DEF     = 10'd63;
    localparam logic [VAL_W-1:0]      LEN_DEF     = 10'd4;
    localparam logic [2:0]            OCT_DEF     = 3'd6;
    localparam logic [VAL_W-1:0]      OCT_MIN     = 10'd3;
    localparam logic [VAL_W-1:0]      OCT_MAX     = 10'd7;

    // character codes
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;

    // semitone codes
    localparam logic [SEMI_W-1:0] SEMI_REST = 4'd0;
    localparam logic [SEMI_W-1:0] SEMI_C    = 4'd1;
    localparam logic [SEMI_W-1:0] SEMI_D    = 4'd3;
    localparam logic [SEMI_W-1:0] SEMI_E    = 4'd5;
    localparam logic [SEMI_W-1:0] SEMI_F    = 4'd6;
    localparam logic [SEMI_W-1:0] SEMI_G    = 4'd8;
    localparam logic [SEMI_W-1:0] SEMI_A    = 4'd10;
    localparam logic [SEMI_W-1:0] SEMI_B    = 4'd12;
    localparam logic [SEMI_W-1:0] SEMI_MAX  = 4'd13;

    typedef enum logic [3:0] {
        PH_TITLE,
        PH_KEY,
        PH_EQ_D,
        PH_EQ_O,
        PH_EQ_B,
        PH_VAL_D,
        PH_VAL_O,
        PH_VAL_B,
        PH_DUR,
        PH_TAIL,
        PH_SHARP,
        PH_DOT,
        PH_OCT
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEMPO_START,
        S_TEMPO_RUN,
        S_NOTE_START,
        S_NOTE_RUN,
        S_NOTE_HOLD
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              final_char;
    } t_in_word;

    typedef struct packed {
        logic [OCT_W-1:0]  octave;
        logic [SEMI_W-1:0] semitone;
        logic [DUR_W-1:0]  duration_ms;
        logic              song_end;
    } t_out_word;

    // pending note, captured when it is closed
    typedef struct packed {
        logic [DIVISOR_W-1:0] div;
        logic                 dot;
        logic [OCT_W-1:0]     oct;
        logic [SEMI_W-1:0]    semi;
        logic                 last;
    } t_snap;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_tempo;
        logic tempo_load;
        logic tempo_keep;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_tempo;
        logic need_note;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### rtl/rtnp_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on rtnp_pkg
`default_nettype none

module rtnp_div
    import rtnp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quotient,
    output logic                       o_busy,
    output logic                       o_done
);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W+1:0]  trial;
    logic                  borrow;

    always_comb begin
        trial  = {1'b0, r_rem, r_quo[DIVIDEND_W-1]} - {2'b00, r_dsr};
        borrow = trial[DIVISOR_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the shifted value fits
            r_rem <= borrow ? {r_rem[DIVISOR_W-2:0], r_quo[DIVIDEND_W-1]}
                            : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ~borrow};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

`default_nettype wire

### rtl/rtnp_dpath.sv
// datapath: character parser, song state, note capture, divider, output register
// depends on rtnp_pkg and rtnp_div
`default_nettype none

module rtnp_dpath
    import rtnp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_st,
    input  wire t_in_word           i_in,
    input  wire logic               i_cfg_we,
    input  wire logic [SHIFT_W-1:0] i_cfg_data,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output t_out_word               o_out
);

    // song state
    t_phase                r_phase;
    logic [VAL_W-1:0]      r_def_len;
    logic [2:0]            r_def_oct;
    logic [VAL_W-1:0]      r_bpm;
    logic [DIVIDEND_W-1:0] r_whole;
    logic [VAL_W-1:0]      r_acc;
    logic [1:0]            r_cnt;
    logic [SEMI_W-1:0]     r_semi;
    logic                  r_dot;
    logic [3:0]            r_noct;
    logic [SHIFT_W-1:0]    r_oct_shift;

    // captured work for the divider
    t_snap                 r_snap;
    logic [DIVIDEND_W-1:0] r_em_whole;
    logic [DIVISOR_W-1:0]  r_tp_div;

    logic                  r_out_valid;
    t_out_word             r_out;

    // next values of one parse step
    t_phase                n_phase;
    logic [VAL_W-1:0]      n_def_len;
    logic [2:0]            n_def_oct;
    logic [VAL_W-1:0]      n_bpm;
    logic [DIVIDEND_W-1:0] n_whole;
    logic [VAL_W-1:0]      n_acc;
    logic [1:0]            n_cnt;
    logic [SEMI_W-1:0]     n_semi;
    logic                  n_dot;
    logic [3:0]            n_noct;
    t_snap                 n_snap;
    logic [DIVISOR_W-1:0]  n_tp_div;
    logic                  emitted;
    logic                  hdr_end;

    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] quotient;
    logic                  div_busy;
    logic                  div_done;
    logic [DUR_W-1:0]      dur;

    function automatic logic [SEMI_W-1:0] letter_code(input logic [CHAR_W-1:0] ch);
        logic [SEMI_W-1:0] code;
        unique case (ch)
            CH_C:    code = SEMI_C;
            CH_D:    code = SEMI_D;
            CH_E:    code = SEMI_E;
            CH_F:    code = SEMI_F;
            CH_G:    code = SEMI_G;
            CH_A:    code = SEMI_A;
            CH_B:    code = SEMI_B;
            default: code = SEMI_REST;
        endcase
        return code;
    endfunction

    // value * 10 + digit, value stays below 100 here
    function automatic logic [VAL_W-1:0] mul10_add(input logic [VAL_W-1:0] v,
                                                   input logic [3:0] dg);
        return VAL_W'((v << 3) + (v << 1) + {6'b0, dg});
    endfunction

    function automatic t_snap make_snap(
        input logic [VAL_W-1:0]   acc,
        input logic [1:0]         cnt,
        input logic [VAL_W-1:0]   dlen,
        input t_phase             ph,
        input logic [3:0]         noct,
        input logic [2:0]         doct,
        input logic [SEMI_W-1:0]  semi,
        input logic               dot,
        input logic [SHIFT_W-1:0] shift,
        input logic               last
    );
        t_snap            s;
        logic [3:0]       oct;
        logic [VAL_W-1:0] dv;
        dv  = (cnt != 2'd0 && acc != '0) ? acc : dlen;
        if (dv == '0) begin
            dv = VAL_W'(1);
        end
        oct    = (ph == PH_OCT) ? noct : {1'b0, doct};
        s.div  = dv;
        s.dot  = dot;
        s.oct  = oct + {2'b00, shift};
        s.semi = semi;
        s.last = last;
        return s;
    endfunction

    always_comb begin
        logic [CHAR_W-1:0] c;
        logic              dig;
        logic [3:0]        d;
        logic              fin;

        c = i_in.text_char;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            c = c + CH_CASE;
        end
        fin = i_in.final_char;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        d   = dig ? c[3:0] : 4'd0;

        n_phase   = r_phase;
        n_def_len = r_def_len;
        n_def_oct = r_def_oct;
        n_bpm     = r_bpm;
        n_whole   = r_whole;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_semi    = r_semi;
        n_dot     = r_dot;
        n_noct    = r_noct;
        n_snap    = r_snap;
        n_tp_div  = r_tp_div;
        emitted   = 1'b0;
        hdr_end   = 1'b0;

        if (r_phase == PH_TITLE) begin
            if (c == CH_COLON) begin
                n_phase = PH_KEY;
            end
        end else if (c != CH_SPACE) begin
            unique case (r_phase) inside
                PH_KEY: begin
                    if (c == CH_D) begin
                        n_phase = PH_EQ_D;
                    end else if (c == CH_O) begin
                        n_phase = PH_EQ_O;
                    end else if (c == CH_B) begin
                        n_phase = PH_EQ_B;
                    end else if (c == CH_COLON) begin
                        hdr_end = 1'b1;
                    end
                end
                PH_EQ_D, PH_EQ_O, PH_EQ_B: begin
                    if (c == CH_EQUAL) begin
                        n_phase = (r_phase == PH_EQ_D) ? PH_VAL_D :
                                  (r_phase == PH_EQ_O) ? PH_VAL_O : PH_VAL_B;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else if (c == CH_COMMA) begin
                        n_phase = PH_KEY;
                    end else if (c == CH_COLON) begin
                        hdr_end = 1'b1;
                    end
                end
                PH_VAL_D, PH_VAL_O, PH_VAL_B: begin
                    if (dig) begin
                        if (r_cnt != 2'd3) begin
                            n_acc = mul10_add(r_acc, d);
                            n_cnt = r_cnt + 2'd1;
                        end
                    end else if (c == CH_COMMA || c == CH_COLON) begin
                        // apply the header value
                        if (r_phase == PH_VAL_D && r_acc != '0) begin
                            n_def_len = r_acc;
                        end else if (r_phase == PH_VAL_O && r_acc >= OCT_MIN &&
                                     r_acc <= OCT_MAX) begin
                            n_def_oct = r_acc[2:0];
                        end else if (r_phase == PH_VAL_B && r_cnt != 2'd0) begin
                            n_bpm = (r_acc == '0) ? BPM_DEF : r_acc;
                        end
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_KEY;
                        hdr_end = (c == CH_COLON);
                    end
                end
                PH_DUR, PH_TAIL, PH_SHARP, PH_DOT, PH_OCT: begin
                    if (c == CH_COMMA) begin
                        n_snap = make_snap(r_acc, r_cnt, r_def_len, r_phase, r_noct,
                                           r_def_oct, r_semi, r_dot, r_oct_shift, fin);
                        emitted = 1'b1;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_semi  = SEMI_REST;
                        n_dot   = 1'b0;
                        n_noct  = '0;
                        n_phase = PH_DUR;
                    end else if (r_phase == PH_DUR) begin
                        if (dig) begin
                            if (r_cnt < 2'd2) begin
                                n_acc = mul10_add(r_acc, d);
                                n_cnt = r_cnt + 2'd1;
                            end
                        end else begin
                            n_semi  = letter_code(c);
                            n_phase = PH_TAIL;
                        end
                    end else if (c == CH_SHARP && r_phase == PH_TAIL) begin
                        if (r_semi != SEMI_REST) begin
                            n_semi = r_semi + 4'd1;
                        end
                        n_phase = PH_SHARP;
                    end else if (c == CH_DOT) begin
                        n_dot = 1'b1;
                        if (r_phase != PH_OCT) begin
                            n_phase = PH_DOT;
                        end
                    end else if (dig && r_phase != PH_OCT) begin
                        n_noct  = d;
                        n_phase = PH_OCT;
                    end
                end
                default: begin
                    n_phase = PH_TITLE;
                end
            endcase
        end

        // end of header: tempo division pending, note section starts
        if (hdr_end) begin
            n_tp_div = (n_bpm == '0) ? BPM_DEF : n_bpm;
            n_acc    = '0;
            n_cnt    = '0;
            n_semi   = SEMI_REST;
            n_dot    = 1'b0;
            n_noct   = '0;
            n_phase  = PH_DUR;
        end

        if (fin) begin
            if (!emitted && n_phase >= PH_DUR && n_phase <= PH_OCT) begin
                n_snap = make_snap(n_acc, n_cnt, n_def_len, n_phase, n_noct,
                                   n_def_oct, n_semi, n_dot, r_oct_shift, 1'b1);
                emitted = 1'b1;
            end
            n_phase   = PH_TITLE;
            n_def_len = LEN_DEF;
            n_def_oct = OCT_DEF;
            n_bpm     = BPM_DEF;
            n_whole   = '0;
            n_acc     = '0;
            n_cnt     = '0;
            n_semi    = SEMI_REST;
            n_dot     = 1'b0;
            n_noct    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TITLE;
            r_def_len   <= LEN_DEF;
            r_def_oct   <= OCT_DEF;
            r_bpm       <= BPM_DEF;
            r_whole     <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_semi      <= SEMI_REST;
            r_dot       <= 1'b0;
            r_noct      <= '0;
            r_oct_shift <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_oct_shift <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_phase   <= n_phase;
                r_def_len <= n_def_len;
                r_def_oct <= n_def_oct;
                r_bpm     <= n_bpm;
                r_whole   <= n_whole;
                r_acc     <= n_acc;
                r_cnt     <= n_cnt;
                r_semi    <= n_semi;
                r_dot     <= n_dot;
                r_noct    <= n_noct;
            end else if (i_cmd.tempo_load && i_cmd.tempo_keep) begin
                r_whole <= {quotient[DIVIDEND_W-3:0], 2'b00};
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_snap   <= n_snap;
            r_tp_div <= n_tp_div;
            if (emitted) begin
                r_em_whole <= r_whole;
            end
        end else if (i_cmd.tempo_load) begin
            // whole note = (60000 / bpm) * 4
            r_em_whole <= {quotient[DIVIDEND_W-3:0], 2'b00};
        end
        if (i_cmd.out_load) begin
            r_out.octave      <= r_snap.oct;
            r_out.semitone    <= r_snap.semi;
            r_out.duration_ms <= dur;
            r_out.song_end    <= r_snap.last;
        end
    end

    // dotted adds half
    assign dur = {1'b0, quotient} +
                 (r_snap.dot ? {2'b00, quotient[DIVIDEND_W-1:1]} : '0);

    assign div_dividend = i_cmd.div_sel_tempo ? TEMPO_NUM : r_em_whole;
    assign div_divisor  = i_cmd.div_sel_tempo ? r_tp_div : r_snap.div;

    rtnp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quotient),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    always_comb begin
        o_st.need_tempo = hdr_end;
        o_st.need_note  = emitted;
        o_st.div_busy   = div_busy;
        o_st.div_done   = div_done;
        o_st.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### rtl/rtnp_ctrl.sv
// controller: sequences character accept, tempo division and note division
// depends on rtnp_pkg
`default_nettype none

module rtnp_ctrl
    import rtnp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_st,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_chain;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_st.need_tempo) begin
                        n_state = S_TEMPO_START;
                    end else if (i_st.need_note) begin
                        n_state = S_NOTE_START;
                    end
                end
            end
            S_TEMPO_START: n_state = S_TEMPO_RUN;
            S_TEMPO_RUN: begin
                if (i_st.div_done) begin
                    n_state = r_chain ? S_NOTE_START : S_IDLE;
                end
            end
            S_NOTE_START: n_state = S_NOTE_RUN;
            S_NOTE_RUN: begin
                if (i_st.div_done) begin
                    n_state = i_st.out_free ? S_IDLE : S_NOTE_HOLD;
                end
            end
            S_NOTE_HOLD: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready          = (r_state == S_IDLE);
        o_cmd.accept        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start     = (r_state == S_TEMPO_START) || (r_state == S_NOTE_START);
        o_cmd.div_sel_tempo = (r_state == S_TEMPO_START);
        o_cmd.tempo_load    = (r_state == S_TEMPO_RUN) && i_st.div_done;
        o_cmd.tempo_keep    = !r_chain;
        o_cmd.out_load      = ((r_state == S_NOTE_RUN) && i_st.div_done && i_st.out_free) ||
                              ((r_state == S_NOTE_HOLD) && i_st.out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.accept) begin
                // header end and song end on one character: two divisions
                r_chain <= i_st.need_tempo && i_st.need_note;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ringtone_text_note_parser.sv
// ring-tone text note parser, top level: controller, datapath, config port
// a character that closes nothing is taken in one cycle, back to back
// a character that closes a note or the header holds off the next one until its division is done
// header end on the final character: two divisions, tempo then note, before the word is shown
// a note word is loaded once its division is done and the output register is free; input waits until then
// synchronous active-low reset: title skip, d=4, o=6, b=63, octave shift 0
`default_nettype none

module ringtone_text_note_parser
    import rtnp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // character words in
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_word           i_in,
    // note words out
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_word               o_out,
    // octave shift register write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [SHIFT_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat st;

    // register writes are to arrive only while idle (the user's duty, not enforced here); the port never stalls
    assign o_cfg_ready = 1'b1;

    // controller: accept, tempo division, note division, output hand-off
    rtnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath: parser state, shared divider, output register
    rtnp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef SYNTH
    // no character taken while the divider works
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.div_busy |-> !o_in_ready)
        else $error("character accepted while divider busy");

    // a new note word never overwrites one still waiting
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("note word overwritten");

    // the divider is never restarted mid-run
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider restarted while busy");

    // the semitone code stays in range
    a_semi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.semitone <= SEMI_MAX))
        else $error("semitone out of range");
`endif

endmodule

`default_nettype wire

### dv/tb_ringtone_text_note_parser.sv
// testbench for ringtone_text_note_parser: directed and random ring-tone texts
// against a cycle-free parser model kept in step at each accepted character word
// depends on rtnp_pkg and the ringtone_text_note_parser rtl
`default_nettype none

module tb_ringtone_text_note_parser;
    import rtnp_pkg::*;

    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int SETTLE_WAIT  = 60;    // covers two back-to-back divisions
    localparam int PHASE_CHARS  = 260;   // character words per random phase

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    t_in_word        in_word = '0;
    logic            out_ready = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [SHIFT_W-1:0] cfg_data = '0;
    wire logic       in_ready;
    wire logic       out_valid;
    wire t_out_word  out_word;
    wire logic       cfg_ready;

    ringtone_text_note_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // parser model state, stepped once per accepted character word
    // ---------------------------------------------------------------
    t_phase              ph_now;
    logic [VAL_W-1:0]    len_dflt;
    logic [OCT_W-1:0]    oct_dflt;
    logic [VAL_W-1:0]    bpm_now;
    logic [DIVIDEND_W-1:0] whole_ms;
    logic [VAL_W-1:0]    num_acc;
    logic [1:0]          num_cnt;
    logic [SEMI_W-1:0]   semi_now;
    logic                dot_now;
    logic [OCT_W-1:0]    oct_note;
    logic [SHIFT_W-1:0]  oct_shift;

    t_out_word pending_notes[$];   // note words still owed by the block
    t_in_word  song_q[$];          // character words of the text being sent
    int errors = 0;
    int n_parsed = 0;              // character words accepted
    int quiet_cycles = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int stall_left = 0;

    function automatic void clear_note();
        num_acc  = '0;
        num_cnt  = '0;
        semi_now = SEMI_REST;
        dot_now  = 1'b0;
        oct_note = '0;
    endfunction

    function automatic void song_reset();
        ph_now   = PH_TITLE;
        len_dflt = LEN_DEF;
        oct_dflt = OCT_W'(OCT_DEF);
        bpm_now  = BPM_DEF;
        whole_ms = '0;
        clear_note();
    endfunction

    // commit a header value when its entry is closed
    function automatic void apply_header();
        if (ph_now == PH_VAL_D && num_acc > 0)
            len_dflt = num_acc;
        else if (ph_now == PH_VAL_O && num_acc >= OCT_MIN && num_acc <= OCT_MAX)
            oct_dflt = OCT_W'(num_acc);
        else if (ph_now == PH_VAL_B && num_cnt > 0)
            bpm_now = (num_acc == 0) ? BPM_DEF : num_acc;
        num_acc = '0;
        num_cnt = '0;
    endfunction

    // second colon: whole-note length from the tempo
    function automatic void close_header();
        logic [VAL_W-1:0] bpm_eff;
        int q;
        bpm_eff = (bpm_now == 0) ? BPM_DEF : bpm_now;
        q = int'(TEMPO_NUM) / int'(bpm_eff);
        whole_ms = DIVIDEND_W'(q * 4);
        clear_note();
        ph_now = PH_DUR;
    endfunction

    function automatic t_out_word emit_note(input logic last);
        t_out_word r;
        int div;
        int dur;
        logic [OCT_W-1:0] o;
        div = (num_cnt > 0 && num_acc > 0) ? int'(num_acc) : int'(len_dflt);
        if (div == 0)
            div = 1;
        dur = int'(whole_ms) / div;
        if (dot_now)
            dur = dur + dur / 2;
        o = (ph_now == PH_OCT) ? oct_note : oct_dflt;
        r.octave      = o + {2'b00, oct_shift};
        r.semitone    = semi_now;
        r.duration_ms = DUR_W'(dur);
        r.song_end    = last;
        clear_note();
        ph_now = PH_DUR;
        return r;
    endfunction

    function automatic void parse_char(input t_in_word w, output bit made,
                                       output t_out_word note);
        logic [CHAR_W-1:0] c;
        bit dig;
        logic [3:0] d;
        made = 1'b0;
        note = '0;
        c = w.text_char;
        if (c >= CH_UP_A && c <= CH_UP_Z)
            c = c + CH_CASE;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        d = dig ? 4'(c - CH_ZERO) : 4'd0;

        if (ph_now == PH_TITLE) begin
            // everything up to the first colon is title
            if (c == CH_COLON)
                ph_now = PH_KEY;
        end else if (c != CH_SPACE) begin
            if (ph_now == PH_KEY) begin
                if (c == CH_D)
                    ph_now = PH_EQ_D;
                else if (c == CH_O)
                    ph_now = PH_EQ_O;
                else if (c == CH_B)
                    ph_now = PH_EQ_B;
                else if (c == CH_COLON)
                    close_header();
            end else if (ph_now >= PH_EQ_D && ph_now <= PH_EQ_B) begin
                if (c == CH_EQUAL) begin
                    ph_now  = t_phase'(ph_now + 4'd3);
                    num_acc = '0;
                    num_cnt = '0;
                end else if (c == CH_COMMA) begin
                    ph_now = PH_KEY;
                end else if (c == CH_COLON) begin
                    close_header();
                end
            end else if (ph_now >= PH_VAL_D && ph_now <= PH_VAL_B) begin
                // header values keep at most three digits
                if (dig) begin
                    if (num_cnt < 3) begin
                        num_acc = VAL_W'(num_acc * 10 + d);
                        num_cnt = num_cnt + 2'd1;
                    end
                end else if (c == CH_COMMA) begin
                    apply_header();
                    ph_now = PH_KEY;
                end else if (c == CH_COLON) begin
                    apply_header();
                    close_header();
                end
            end else begin
                if (c == CH_COMMA) begin
                    note = emit_note(w.final_char);
                    made = 1'b1;
                end else if (ph_now == PH_DUR) begin
                    if (dig) begin
                        // only the first two duration digits count
                        if (num_cnt < 2) begin
                            num_acc = VAL_W'(num_acc * 10 + d);
                            num_cnt = num_cnt + 2'd1;
                        end
                    end else begin
                        case (c)
                            CH_C:    semi_now = SEMI_C;
                            CH_D:    semi_now = SEMI_D;
                            CH_E:    semi_now = SEMI_E;
                            CH_F:    semi_now = SEMI_F;
                            CH_G:    semi_now = SEMI_G;
                            CH_A:    semi_now = SEMI_A;
                            CH_B:    semi_now = SEMI_B;
                            default: semi_now = SEMI_REST;
                        endcase
                        ph_now = PH_TAIL;
                    end
                end else if (c == CH_SHARP && ph_now == PH_TAIL) begin
                    if (semi_now != SEMI_REST)
                        semi_now = semi_now + 4'd1;
                    ph_now = PH_SHARP;
                end else if (c == CH_DOT) begin
                    dot_now = 1'b1;
                    if (ph_now != PH_OCT)
                        ph_now = PH_DOT;
                end else if (dig && ph_now != PH_OCT) begin
                    oct_note = d;
                    ph_now = PH_OCT;
                end
            end
        end

        // last character closes any open note, then the song starts over
        if (w.final_char) begin
            if (!made && ph_now >= PH_DUR) begin
                note = emit_note(1'b1);
                made = 1'b1;
            end
            song_reset();
        end
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: model step on each character word, check on each note
    // word, octave shift on each config word, and the no-progress watchdog
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_out_word want_note;
        bit made;
        bit moved;
        if (!rst_n) begin
            song_reset();
            oct_shift = '0;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (in_valid && in_ready) begin
                n_parsed++;
                parse_char(in_word, made, want_note);
                if (made)
                    pending_notes.push_back(want_note);
                moved = 1'b1;
            end
            if (out_valid && out_ready) begin
                moved = 1'b1;
                if (pending_notes.size() == 0) begin
                    $error("note word with none pending: %p", out_word);
                    errors++;
                end else begin
                    want_note = pending_notes.pop_front();
                    check_field("octave", int'(want_note.octave), int'(out_word.octave));
                    check_field("semitone", int'(want_note.semitone),
                                int'(out_word.semitone));
                    check_field("duration_ms", int'(want_note.duration_ms),
                                int'(out_word.duration_ms));
                    check_field("song_end", int'(want_note.song_end),
                                int'(out_word.song_end));
                end
            end
            if (cfg_valid && cfg_ready) begin
                oct_shift = cfg_data;
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_ringtone_text_note_parser: FAIL");
                $finish;
            end
        end
    end

    // receiver back-pressure: random stalls on out_ready
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one character word; valid stays up into the next word when no gap
    task automatic send_char(input t_in_word w);
        @(negedge clk);
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input bit fin_last);
        t_in_word w;
        for (int i = 0; i < s.len(); i++) begin
            w.text_char  = s[i];
            w.final_char = fin_last && (i == s.len() - 1);
            send_char(w);
        end
    endtask

    task automatic send_song();
        for (int i = 0; i < song_q.size(); i++)
            send_char(song_q[i]);
    endtask

    // drop valid, let every owed note word drain, then let a trailing
    // header division finish before anything else happens
    task automatic wait_for_notes();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_octave_shift(input logic [SHIFT_W-1:0] v);
        wait_for_notes();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // random text builder
    // ---------------------------------------------------------------
    function automatic void push_char(input logic [CHAR_W-1:0] c);
        t_in_word w;
        w.text_char  = c;
        w.final_char = 1'b0;
        song_q.push_back(w);
    endfunction

    function automatic void push_number(input int n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic void mark_final();
        t_in_word w;
        w = song_q.pop_back();
        w.final_char = 1'b1;
        song_q.push_back(w);
    endfunction

    task automatic build_song();
        int len;
        int pick;
        int keep;
        logic [CHAR_W-1:0] c;
        string letters;
        t_in_word w;
        letters = "cdefgabp";
        song_q.delete();

        // pure noise now and then: any byte, any last-character flag
        if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(30, 5)) begin
                w.text_char  = CHAR_W'($urandom_range(255));
                w.final_char = ($urandom_range(7) == 0);
                song_q.push_back(w);
            end
            mark_final();
            return;
        end

        // title, mostly short, sometimes long
        len = ($urandom_range(15) == 0) ? $urandom_range(80, 30) : $urandom_range(6);
        repeat (len) begin
            c = CHAR_W'($urandom_range(255));
            if (c == CH_COLON)
                c = c + 8'd1;
            push_char(c);
        end
        push_char(CH_COLON);

        // header entries in random order, some malformed
        for (int k = 0; k < $urandom_range(3); k++) begin
            if (k > 0)
                push_char(CH_COMMA);
            if ($urandom_range(7) == 0)
                push_char(CH_SPACE);
            pick = $urandom_range(9);
            c = (pick < 3) ? CH_D : (pick < 6) ? CH_O : (pick < 9) ? CH_B : "q";
            if ($urandom_range(1))
                c = c - CH_CASE;
            push_char(c);
            if ($urandom_range(11) != 0)
                push_char(CH_EQUAL);
            if ($urandom_range(15) != 0) begin
                if ($urandom_range(7) == 0)
                    push_number($urandom_range(9999));
                else if (pick < 3)
                    push_number(1 << $urandom_range(5));
                else if (pick < 6)
                    push_number($urandom_range(7, 3));
                else
                    push_number($urandom_range(250, 20));
            end
            if ($urandom_range(9) == 0)
                push_char("x");
        end
        push_char(CH_COLON);

        // notes with random content
        for (int i = 0; i < $urandom_range(8, 1); i++) begin
            if (i > 0)
                push_char(CH_COMMA);
            if ($urandom_range(11) == 0)
                push_char(CH_SPACE);
            if ($urandom_range(9) < 6)
                push_number(($urandom_range(7) == 0) ? $urandom_range(999)
                                                     : (1 << $urandom_range(5)));
            pick = $urandom_range(19);
            if (pick < 16) begin
                c = letters[pick % 8];
                if (pick >= 8)
                    c = c - CH_CASE;
                push_char(c);
            end else if (pick < 19) begin
                push_char(CHAR_W'($urandom_range(255)));
            end
            if ($urandom_range(9) < 3)
                push_char(CH_SHARP);
            if ($urandom_range(9) < 2)
                push_char(CH_DOT);
            if ($urandom_range(1))
                push_number(($urandom_range(3) == 0) ? $urandom_range(9)
                                                     : $urandom_range(7, 4));
            if ($urandom_range(9) == 0)
                push_char(CH_DOT);
            if ($urandom_range(15) == 0)
                push_char("h");
        end
        if ($urandom_range(5) == 0)
            push_char(CH_COMMA);

        // broken text: cut short, last character wherever the cut falls
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(song_q.size(), 1);
            while (song_q.size() > keep)
                void'(song_q.pop_back());
        end
        mark_final();
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // full header, every letter form, sharp, b sharp, dots, octaves, rest
    task automatic test_header_and_notes();
        in_idle_pct  = 30;
        out_idle_pct = 30;
        send_text("tune:d=8,o=5,b=120:c,d#6.,4p,32b#,16a7.,e,f,g.#,a", 1'b1);
    endtask

    // upper case, spaces in header and notes, zero tempo, sharp on a rest,
    // comma as the last character
    task automatic test_case_and_spaces();
        send_text("Up Case:D=16, O=7 ,B=0: C# , E , P#. ,", 1'b1);
    endtask

    // unknown key, key without value, zero length, octave out of range,
    // four-digit tempo, stray character inside a value
    task automatic test_header_repairs();
        send_text("k:q=5,o,d=0,o=9,b=1234,d=1x6:c", 1'b1);
    endtask

    // extra duration digits, unknown letter, empty note, dot after octave,
    // stray characters, lowest and highest byte values
    task automatic test_note_repairs();
        t_in_word w;
        send_text("n::123f,x#,,7c6.,e5h.,b,", 1'b0);
        w.text_char  = 8'h00;
        w.final_char = 1'b0;
        send_char(w);
        w.text_char  = 8'hFF;
        w.final_char = 1'b1;
        send_char(w);
    endtask

    // last character in title, in header, on the header colon, and a
    // note made of a length only
    task automatic test_final_outside_notes();
        send_text("abc", 1'b1);
        send_text("t:d=4", 1'b1);
        send_text("t:b=200:", 1'b1);
        send_text("t::8", 1'b1);
    endtask

    // longest note and highest octave with the largest shift, shortest note
    task automatic test_extremes();
        write_octave_shift(2'd3);
        send_text("x:d=1,o=3,b=1:c.9,p", 1'b1);
        send_text("x:b=999:99c,32b#9.", 1'b1);
    endtask

    task automatic test_random_songs();
        logic [SHIFT_W-1:0] shifts[4];
        int stop_at;
        shifts = '{2'd2, 2'd1, 2'd0, 2'd3};
        foreach (shifts[p]) begin
            write_octave_shift(shifts[p]);
            stop_at = n_parsed + PHASE_CHARS;
            while (n_parsed < stop_at) begin
                // some songs run with no gaps at all
                in_idle_pct  = ($urandom_range(3) == 0) ? 0 : 30;
                out_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
                build_song();
                send_song();
            end
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_back_to_back();
        int stop_at;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        stop_at = n_parsed + 100;
        while (n_parsed < stop_at) begin
            build_song();
            send_song();
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_and_notes();
        test_case_and_spaces();
        test_header_repairs();
        test_note_repairs();
        test_final_outside_notes();
        test_extremes();
        test_random_songs();
        test_back_to_back();

        wait_for_notes();
        if (errors == 0)
            $display("tb_ringtone_text_note_parser: PASS");
        else
            $display("tb_ringtone_text_note_parser: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
